// File: src/bthe_pkg.sv
package bthe_pkg;

   localparam int BIN_COUNT = 16;
   localparam int PC_W = 6;

   localparam logic [2:0] OP_WRITE      = 3'd0;
   localparam logic [2:0] OP_READ       = 3'd1;
   localparam logic [2:0] OP_SPLIT      = 3'd2;
   localparam logic [2:0] OP_MERGE_NEXT = 3'd3;
   localparam logic [2:0] OP_MERGE_PREV = 3'd4;
   localparam logic [2:0] OP_SIZE_CLASS = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ADDR = 2'd1;
   localparam logic [1:0] ST_SIZE = 2'd2;

   localparam logic CSR_HEAP_LOW = 1'b0;
   localparam logic CSR_HEAP_TOP = 1'b1;

   localparam logic [13:0] HEAP_LOW_RESET = 14'd0;
   localparam logic [13:0] HEAP_TOP_RESET = 14'd8192;

   localparam logic [63:0] TAG_SIZE_BITS  = ~64'hF;
   localparam logic [63:0] TAG_ALLOC      = 64'h1;
   localparam logic [63:0] SMALLEST_BLOCK = 64'd48;
   localparam logic [63:0] ROUND_ADD      = 64'd39;
   localparam logic [5:0]  BIN_BASE       = 6'd5;
   localparam logic [5:0]  BIN_LAST       = 6'(BIN_COUNT - 1);

   localparam logic [2:0] LOD_NONE = 3'd0;
   localparam logic [2:0] LOD_32   = 3'd1;
   localparam logic [2:0] LOD_16   = 3'd2;
   localparam logic [2:0] LOD_8    = 3'd3;
   localparam logic [2:0] LOD_4    = 3'd4;
   localparam logic [2:0] LOD_2    = 3'd5;
   localparam logic [2:0] LOD_1    = 3'd6;

   typedef enum logic [1:0] {ADDR_B, ADDR_PREV, ADDR_NXT, ADDR_PTR} addr_sel_type;
   typedef enum logic [2:0] {WD_VAL, WD_VAL_ALLOC, WD_WHOLE_ALLOC, WD_EXTRA, WD_SUM} wd_sel_type;
   typedef enum logic [1:0] {TAG_HOLD, TAG_MEM, TAG_MAXV} tag_sel_type;
   typedef enum logic [1:0] {PTR_HOLD, PTR_REM, PTR_PV} ptr_sel_type;
   typedef enum logic [3:0] {
      C_NEVER, C_OUT_MEM, C_SPLIT_BIG, C_EXTRA_SMALL, C_REM_OUT,
      C_AT_END, C_NEXT_OUT, C_ALLOC, C_AT_LOW, C_PREV_OUT
   } cond_type;
   typedef enum logic [2:0] {
      FIN_NONE, FIN_EMPTY, FIN_READ, FIN_ADDR_ERR, FIN_SIZE_ERR,
      FIN_BLK_B, FIN_BLK_PTR, FIN_SIZE_CLASS
   } fin_type;
   typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_type;

   typedef struct packed {
      addr_sel_type    addr_sel;
      logic            mem_we;
      logic            mem_re;
      wd_sel_type      wd_sel;
      tag_sel_type     tag_sel;
      ptr_sel_type     ptr_sel;
      logic [2:0]      lod;
      cond_type        cond;
      logic [PC_W-1:0] target;
      fin_type         fin;
   } ctrl_type;

   typedef struct packed {
      logic [12:0] blk;
      logic        has;
      logic [63:0] rdata;
      logic [63:0] rtotal;
      logic [3:0]  bin;
      logic [1:0]  status;
   } res_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_stat_type;

   localparam ctrl_type CTRL_NOP = '{ADDR_B, 1'b0, 1'b0, WD_VAL, TAG_HOLD, PTR_HOLD,
                                     LOD_NONE, C_NEVER, '0, FIN_NONE};

   localparam logic [PC_W-1:0] STEP_F_EMPTY = 6'd0;
   localparam logic [PC_W-1:0] STEP_F_AERR  = 6'd1;
   localparam logic [PC_W-1:0] STEP_F_SERR  = 6'd2;
   localparam logic [PC_W-1:0] STEP_F_BLKB  = 6'd3;
   localparam logic [PC_W-1:0] STEP_W0      = 6'd4;
   localparam logic [PC_W-1:0] STEP_W1      = 6'd5;
   localparam logic [PC_W-1:0] STEP_R0      = 6'd6;
   localparam logic [PC_W-1:0] STEP_R1      = 6'd7;
   localparam logic [PC_W-1:0] STEP_S0      = 6'd8;
   localparam logic [PC_W-1:0] STEP_S1      = 6'd9;
   localparam logic [PC_W-1:0] STEP_S2      = 6'd10;
   localparam logic [PC_W-1:0] STEP_S3      = 6'd11;
   localparam logic [PC_W-1:0] STEP_S4      = 6'd12;
   localparam logic [PC_W-1:0] STEP_S5      = 6'd13;
   localparam logic [PC_W-1:0] STEP_S_ALL   = 6'd14;
   localparam logic [PC_W-1:0] STEP_M0      = 6'd15;
   localparam logic [PC_W-1:0] STEP_M1      = 6'd16;
   localparam logic [PC_W-1:0] STEP_M2      = 6'd17;
   localparam logic [PC_W-1:0] STEP_M3      = 6'd18;
   localparam logic [PC_W-1:0] STEP_M4      = 6'd19;
   localparam logic [PC_W-1:0] STEP_P0      = 6'd20;
   localparam logic [PC_W-1:0] STEP_P1      = 6'd21;
   localparam logic [PC_W-1:0] STEP_P2      = 6'd22;
   localparam logic [PC_W-1:0] STEP_P3      = 6'd23;
   localparam logic [PC_W-1:0] STEP_P4      = 6'd24;
   localparam logic [PC_W-1:0] STEP_P5      = 6'd25;
   localparam logic [PC_W-1:0] STEP_Z0      = 6'd26;
   localparam logic [PC_W-1:0] STEP_Z1      = 6'd27;
   localparam logic [PC_W-1:0] STEP_Z2      = 6'd28;
   localparam logic [PC_W-1:0] STEP_Z3      = 6'd29;
   localparam logic [PC_W-1:0] STEP_Z4      = 6'd30;
   localparam logic [PC_W-1:0] STEP_Z5      = 6'd31;
   localparam logic [PC_W-1:0] STEP_Z6      = 6'd32;
   localparam logic [PC_W-1:0] STEP_Z7      = 6'd33;

   function automatic logic [PC_W-1:0] entry_step(input logic [2:0] op);
      logic [PC_W-1:0] s;
      case (op)
         OP_WRITE:      s = STEP_W0;
         OP_READ:       s = STEP_R0;
         OP_SPLIT:      s = STEP_S0;
         OP_MERGE_NEXT: s = STEP_M0;
         OP_MERGE_PREV: s = STEP_P0;
         OP_SIZE_CLASS: s = STEP_Z0;
         default:       s = STEP_F_EMPTY;
      endcase
      return s;
   endfunction

   function automatic ctrl_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = CTRL_NOP;
      case (pc)
         STEP_F_EMPTY: w.fin = FIN_EMPTY;
         STEP_F_AERR:  w.fin = FIN_ADDR_ERR;
         STEP_F_SERR:  w.fin = FIN_SIZE_ERR;
         STEP_F_BLKB:  w.fin = FIN_BLK_B;
         // write word
         STEP_W0: begin
            w.cond = C_OUT_MEM;   w.target = STEP_F_AERR;
         end
         STEP_W1: begin
            w.mem_we = 1'b1;      w.wd_sel = WD_VAL;       w.fin = FIN_EMPTY;
         end
         // read word
         STEP_R0: begin
            w.mem_re = 1'b1;      w.cond = C_OUT_MEM;      w.target = STEP_F_AERR;
         end
         STEP_R1: w.fin = FIN_READ;
         // split
         STEP_S0: begin
            w.mem_re = 1'b1;      w.cond = C_OUT_MEM;      w.target = STEP_F_AERR;
         end
         STEP_S1: begin
            w.tag_sel = TAG_MEM;  w.cond = C_SPLIT_BIG;    w.target = STEP_F_SERR;
         end
         STEP_S2: begin
            w.cond = C_EXTRA_SMALL; w.target = STEP_S_ALL;
         end
         STEP_S3: begin
            w.ptr_sel = PTR_REM;  w.cond = C_REM_OUT;      w.target = STEP_F_AERR;
         end
         STEP_S4: begin
            w.mem_we = 1'b1;      w.wd_sel = WD_VAL_ALLOC;
         end
         STEP_S5: begin
            w.addr_sel = ADDR_PTR; w.mem_we = 1'b1; w.wd_sel = WD_EXTRA;
            w.fin = FIN_BLK_PTR;
         end
         STEP_S_ALL: begin
            w.mem_we = 1'b1;      w.wd_sel = WD_WHOLE_ALLOC; w.fin = FIN_EMPTY;
         end
         // merge with next
         STEP_M0: begin
            w.mem_re = 1'b1;      w.cond = C_OUT_MEM;      w.target = STEP_F_AERR;
         end
         STEP_M1: begin
            w.tag_sel = TAG_MEM;  w.cond = C_AT_END;       w.target = STEP_F_BLKB;
         end
         STEP_M2: begin
            w.addr_sel = ADDR_NXT; w.mem_re = 1'b1;
            w.cond = C_NEXT_OUT;  w.target = STEP_F_AERR;
         end
         STEP_M3: begin
            w.cond = C_ALLOC;     w.target = STEP_F_BLKB;
         end
         STEP_M4: begin
            w.mem_we = 1'b1;      w.wd_sel = WD_SUM;       w.fin = FIN_BLK_B;
         end
         // merge with previous
         STEP_P0: begin
            w.mem_re = 1'b1;      w.cond = C_OUT_MEM;      w.target = STEP_F_AERR;
         end
         STEP_P1: begin
            w.tag_sel = TAG_MEM;  w.addr_sel = ADDR_PREV;  w.mem_re = 1'b1;
            w.cond = C_AT_LOW;    w.target = STEP_F_BLKB;
         end
         STEP_P2: begin
            w.cond = C_ALLOC;     w.target = STEP_F_BLKB;
         end
         STEP_P3: begin
            w.ptr_sel = PTR_PV;   w.cond = C_PREV_OUT;     w.target = STEP_F_AERR;
         end
         STEP_P4: begin
            w.addr_sel = ADDR_PTR; w.mem_re = 1'b1;
         end
         STEP_P5: begin
            w.addr_sel = ADDR_PTR; w.mem_we = 1'b1; w.wd_sel = WD_SUM;
            w.fin = FIN_BLK_PTR;
         end
         // size class: leading-one search, one halving per step
         STEP_Z0: w.tag_sel = TAG_MAXV;
         STEP_Z1: w.lod = LOD_32;
         STEP_Z2: w.lod = LOD_16;
         STEP_Z3: w.lod = LOD_8;
         STEP_Z4: w.lod = LOD_4;
         STEP_Z5: w.lod = LOD_2;
         STEP_Z6: w.lod = LOD_1;
         STEP_Z7: w.fin = FIN_SIZE_CLASS;
         default: w.fin = FIN_EMPTY;
      endcase
      return w;
   endfunction

endpackage

// File: src/boundary_tag_heap_engine.sv
// One request at a time; the next is taken the cycle after the final microcode step.
// The steps per operation are set by the single-port heap RAM and the six-step leading-one search.
// Reset clears the sequencer, the response valid and the CSRs (heap_low 0, heap_top 8192);
// the heap RAM is not cleared, its words are undefined until written.
module boundary_tag_heap_engine #(
   parameter int HEAP_WORDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [12:0] req_address,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_block_address,
   output logic        rsp_has_block,
   output logic [63:0] rsp_read_data,
   output logic [63:0] rsp_rounded_total,
   output logic [3:0]  rsp_size_bin,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [13:0] csr_wdata
);
   import bthe_pkg::*;

   logic         start, out_free, cond_hit;
   ctrl_type     ctrl;
   seq_stat_type seq_stat;
   res_type      res;

   logic [13:0]  heap_low_ff, heap_low_in;
   logic [13:0]  heap_top_ff, heap_top_in;
   logic         rsp_valid_ff, rsp_valid_in;
   res_type      rsp_res_ff, rsp_res_in;

   assign req_stall = seq_stat.busy;
   assign start     = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   bthe_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (req_operation),
      .out_free (out_free),
      .cond_hit (cond_hit),
      .ctrl     (ctrl),
      .stat     (seq_stat)
   );

   bthe_dp #(.HEAP_WORDS(HEAP_WORDS)) u_dp (
      .clock    (clock),
      .start    (start),
      .address  (req_address),
      .value    (req_value),
      .heap_low (heap_low_ff),
      .heap_top (heap_top_ff),
      .ctrl     (ctrl),
      .cond_hit (cond_hit),
      .res      (res)
   );

   always_comb begin
      heap_low_in = heap_low_ff;
      heap_top_in = heap_top_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEAP_LOW: heap_low_in = csr_wdata;
            CSR_HEAP_TOP: heap_top_in = csr_wdata;
            default:      heap_low_in = heap_low_ff;
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (seq_stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_low_ff  <= HEAP_LOW_RESET;
         heap_top_ff  <= HEAP_TOP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         heap_low_ff  <= heap_low_in;
         heap_top_ff  <= heap_top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_res_ff.blk;
   assign rsp_has_block     = rsp_res_ff.has;
   assign rsp_read_data     = rsp_res_ff.rdata;
   assign rsp_rounded_total = rsp_res_ff.rtotal;
   assign rsp_size_bin      = rsp_res_ff.bin;
   assign rsp_status        = rsp_res_ff.status;

`ifndef SYNTHESIS
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> seq_stat.busy)
      else $error("sequencer not started after request transfer");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(seq_stat.done))
      else $error("response valid without a finished step");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_has_block && rsp_read_data == '0
         && rsp_rounded_total == '0 && rsp_size_bin == '0 && rsp_block_address == '0)
      else $error("error response carries data");

   a_block_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_block |-> rsp_status == ST_OK)
      else $error("block returned with error status");
`endif

endmodule

// File: src/bthe_ram.sv
module bthe_ram #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [63:0]              wdata,
   output logic [63:0]              rdata
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: src/bthe_seq.sv
module bthe_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2:0]             op,
   input  logic                   out_free,
   input  logic                   cond_hit,
   output bthe_pkg::ctrl_type     ctrl,
   output bthe_pkg::seq_stat_type stat
);
   import bthe_pkg::*;

   seq_state_type   state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      ctrl     = CTRL_NOP;
      stat     = '0;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               pc_in    = entry_step(op);
            end
         end
         SEQ_RUN: begin
            ctrl      = ucode_rom(pc_ff);
            stat.busy = 1'b1;
            if (ctrl.fin != FIN_NONE) begin
               // final step holds until the result register can take it
               if (out_free) begin
                  stat.done = 1'b1;
                  state_in  = SEQ_IDLE;
               end
            end else if (cond_hit) begin
               pc_in = ctrl.target;
            end else begin
               pc_in = pc_ff + PC_W'(1);
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

endmodule

// File: src/bthe_dp.sv
module bthe_dp #(
   parameter int HEAP_WORDS = 1024
) (
   input  logic              clock,
   input  logic              start,
   input  logic [12:0]       address,
   input  logic [63:0]       value,
   input  logic [13:0]       heap_low,
   input  logic [13:0]       heap_top,
   input  bthe_pkg::ctrl_type ctrl,
   output logic              cond_hit,
   output bthe_pkg::res_type res
);
   import bthe_pkg::*;

   localparam int AW = $clog2(HEAP_WORDS);
   localparam int CW = (AW + 4 > 15) ? AW + 4 : 15;
   localparam logic [CW-1:0] MEM_C = CW'(HEAP_WORDS * 8);

   logic [12:0]   addr_ff, addr_in;
   logic [63:0]   val_ff, val_in;
   logic [63:0]   tag_ff, tag_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [5:0]    top_ff, top_in;

   logic [AW-1:0] mem_addr;
   logic [63:0]   mem_wdata, mem_q;

   logic [CW-1:0] b_c, eh_c, hl_c, nxt_c, rem_c, pv_c;
   logic [AW-1:0] wb;
   logic [63:0]   q_size, t_size, sum, extra, rnd_raw, rnd, maxv, lod_hi;
   logic [5:0]    lod_sh, idx;
   logic [AW+2:0] ptr_byte;

   bthe_ram #(.DEPTH(HEAP_WORDS)) u_ram (
      .clock (clock),
      .we    (ctrl.mem_we),
      .re    (ctrl.mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_q)
   );

   always_comb begin
      b_c      = CW'(addr_ff);
      eh_c     = CW'(heap_top);
      hl_c     = CW'(heap_low);
      wb       = AW'(addr_ff[12:3]);
      q_size   = mem_q & TAG_SIZE_BITS;
      t_size   = tag_ff & TAG_SIZE_BITS;
      sum      = t_size + q_size;
      extra    = t_size - val_ff;
      nxt_c    = b_c + t_size[CW-1:0];
      rem_c    = b_c + val_ff[CW-1:0];
      pv_c     = b_c - q_size[CW-1:0];
      rnd_raw  = (val_ff + ROUND_ADD) & TAG_SIZE_BITS;
      rnd      = (rnd_raw < SMALLEST_BLOCK) ? SMALLEST_BLOCK : rnd_raw;
      maxv     = (val_ff < SMALLEST_BLOCK) ? SMALLEST_BLOCK : val_ff;
      lod_sh   = 6'(7'd64 >> ctrl.lod);
      lod_hi   = tag_ff >> lod_sh;
      idx      = top_ff - BIN_BASE;
      if (idx > BIN_LAST) begin
         idx = BIN_LAST;
      end
      ptr_byte = {ptr_ff, 3'b000};
   end

   always_comb begin
      case (ctrl.cond)
         C_NEVER:       cond_hit = 1'b0;
         C_OUT_MEM:     cond_hit = b_c >= MEM_C;
         C_SPLIT_BIG:   cond_hit = val_ff > q_size;
         C_EXTRA_SMALL: cond_hit = extra < SMALLEST_BLOCK;
         C_REM_OUT:     cond_hit = (|val_ff[63:CW]) || (val_ff[CW-1:0] >= MEM_C - b_c);
         C_AT_END:      cond_hit = (b_c >= eh_c) || (|q_size[63:CW])
                                   || (q_size[CW-1:0] >= eh_c - b_c);
         C_NEXT_OUT:    cond_hit = (|t_size[63:CW]) || (t_size[CW-1:0] >= MEM_C - b_c);
         C_ALLOC:       cond_hit = mem_q[0];
         C_AT_LOW:      cond_hit = b_c <= hl_c;
         C_PREV_OUT:    cond_hit = (|q_size[63:CW]) || (q_size[CW-1:0] > b_c);
         default:       cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      case (ctrl.addr_sel)
         ADDR_B:    mem_addr = wb;
         ADDR_PREV: mem_addr = wb - AW'(1);
         ADDR_NXT:  mem_addr = nxt_c[AW+2:3];
         ADDR_PTR:  mem_addr = ptr_ff;
         default:   mem_addr = wb;
      endcase
      case (ctrl.wd_sel)
         WD_VAL:         mem_wdata = val_ff;
         WD_VAL_ALLOC:   mem_wdata = val_ff | TAG_ALLOC;
         WD_WHOLE_ALLOC: mem_wdata = t_size | TAG_ALLOC;
         WD_EXTRA:       mem_wdata = extra;
         WD_SUM:         mem_wdata = sum;
         default:        mem_wdata = val_ff;
      endcase
   end

   always_comb begin
      addr_in = addr_ff;
      val_in  = val_ff;
      tag_in  = tag_ff;
      ptr_in  = ptr_ff;
      top_in  = top_ff;
      if (start) begin
         addr_in = {address[12:3], 3'b000};
         val_in  = value;
      end
      case (ctrl.tag_sel)
         TAG_HOLD: tag_in = tag_ff;
         TAG_MEM:  tag_in = mem_q;
         TAG_MAXV: begin
            tag_in = maxv;
            top_in = '0;
         end
         default:  tag_in = tag_ff;
      endcase
      if (ctrl.lod != LOD_NONE && lod_hi != '0) begin
         tag_in = lod_hi;
         top_in = top_ff | lod_sh;
      end
      case (ctrl.ptr_sel)
         PTR_HOLD: ptr_in = ptr_ff;
         PTR_REM:  ptr_in = rem_c[AW+2:3];
         PTR_PV:   ptr_in = pv_c[AW+2:3];
         default:  ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      val_ff  <= val_in;
      tag_ff  <= tag_in;
      ptr_ff  <= ptr_in;
      top_ff  <= top_in;
   end

   always_comb begin
      res = '0;
      case (ctrl.fin)
         FIN_NONE:     res = '0;
         FIN_EMPTY:    res = '0;
         FIN_READ:     res.rdata = mem_q;
         FIN_ADDR_ERR: res.status = ST_ADDR;
         FIN_SIZE_ERR: res.status = ST_SIZE;
         FIN_BLK_B: begin
            res.blk = addr_ff;
            res.has = 1'b1;
         end
         FIN_BLK_PTR: begin
            res.blk = 13'(ptr_byte);
            res.has = 1'b1;
         end
         FIN_SIZE_CLASS: begin
            res.rtotal = rnd;
            res.bin    = idx[3:0];
         end
         default:      res = '0;
      endcase
   end

endmodule
